### rtl/convolutional_encoder_unit_macros.svh
// Assertion macros used by the convolutional encoder back end.
`ifndef CONVOLUTIONAL_ENCODER_UNIT_MACROS_SVH
`define CONVOLUTIONAL_ENCODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CENC_ASSERT_IMP(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CENC_ASSERT_NXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CENC_ASSERT_IMP(label, ck, rst_n, ante, cons, msg)
`define CENC_ASSERT_NXT(label, ck, rst_n, ante, cons, msg)
`endif
`endif

### rtl/cenc_pkg.sv
// Types and constants shared by the convolutional encoder modules.
`timescale 1ns / 1ps
package cenc_pkg;
	localparam int MAX_K = 9;
	localparam int MAX_GEN = 4;
	localparam int ST_W = MAX_K - 1;
	localparam int K_W = $clog2(MAX_K + 1);
	localparam int MASK_W = 9;
	localparam int CODE_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 9;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);
	localparam logic [Q_CW-1:0] Q_FULL = Q_CW'(Q_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CONSTRAINT_LENGTH = 3'd0,
		REG_NUM_GENERATORS    = 3'd1,
		REG_GENERATOR_0       = 3'd2,
		REG_GENERATOR_1       = 3'd3,
		REG_GENERATOR_2       = 3'd4,
		REG_GENERATOR_3       = 3'd5,
		REG_FEEDBACK_MASK     = 3'd6,
		REG_TERMINATE_ENABLE  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [K_W-1:0] k;
		logic [K_W-1:0] k_minus1;
		logic [MAX_GEN-1:0] gen_en;
		logic [MAX_GEN-1:0][MASK_W-1:0] gen;
		logic [MASK_W-1:0] fb;
		logic term;
	} cfg_t;

	typedef struct packed {
		logic info_bit;
		logic frame_end;
		logic tail_req;
	} q_item_t;
endpackage

### rtl/cenc_if.sv
// Handshake interfaces for the input, result and configuration channels.
`timescale 1ns / 1ps
interface cenc_in_if;
	logic valid;
	logic ready;
	logic info_bit;
	logic frame_end;
	modport source (output valid, output info_bit, output frame_end, input ready);
	modport sink (input valid, input info_bit, input frame_end, output ready);
endinterface

interface cenc_out_if;
	logic valid;
	logic ready;
	logic [3:0] code_bits;
	logic is_tail;
	logic last_of_run;
	modport source (output valid, output code_bits, output is_tail, output last_of_run,
		input ready);
	modport sink (input valid, input code_bits, input is_tail, input last_of_run,
		output ready);
endinterface

interface cenc_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [8:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/cenc_regs.sv
// Configuration register file with derived effective settings.
`timescale 1ns / 1ps
module cenc_regs
	import cenc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	cenc_cfg_if.sink cfg,
	output cfg_t settings
);
	logic [3:0] k_raw_q;
	logic [2:0] n_raw_q;
	logic [MAX_GEN-1:0][MASK_W-1:0] gen_q;
	logic [MASK_W-1:0] fb_q;
	logic term_q;
	logic [3:0] n_eff;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_raw_q <= 4'd7;
			n_raw_q <= 3'd2;
			gen_q[0] <= 9'd121;
			gen_q[1] <= 9'd91;
			gen_q[2] <= '0;
			gen_q[3] <= '0;
			fb_q <= '0;
			term_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_CONSTRAINT_LENGTH: k_raw_q <= cfg.data[3:0];
				REG_NUM_GENERATORS: n_raw_q <= cfg.data[2:0];
				REG_GENERATOR_0: gen_q[0] <= cfg.data;
				REG_GENERATOR_1: gen_q[1] <= cfg.data;
				REG_GENERATOR_2: gen_q[2] <= cfg.data;
				REG_GENERATOR_3: gen_q[3] <= cfg.data;
				REG_FEEDBACK_MASK: fb_q <= cfg.data;
				REG_TERMINATE_ENABLE: term_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (k_raw_q < 4'd2) begin
			settings.k = K_W'(2);
		end else if (K_W'(k_raw_q) > K_W'(MAX_K)) begin
			settings.k = K_W'(MAX_K);
		end else begin
			settings.k = K_W'(k_raw_q);
		end
		settings.k_minus1 = settings.k - K_W'(1);
		n_eff = (n_raw_q > 3'(MAX_GEN)) ? 4'(MAX_GEN) : 4'(n_raw_q);
		for (int p = 0; p < MAX_GEN; p++) begin
			settings.gen_en[p] = (p < int'(n_eff));
		end
		settings.gen = gen_q;
		settings.fb = fb_q;
		settings.term = term_q;
	end
endmodule

### rtl/cenc_front.sv
// Front end: accepts input transactions, tags frame ends that need a tail, and queues them.
`timescale 1ns / 1ps
module cenc_front
	import cenc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	cenc_in_if.sink info,
	input cfg_t settings,
	output logic q_valid,
	output q_item_t q_item,
	input logic q_pop
);
	q_item_t mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	logic push;

	assign info.ready = (count_q != Q_FULL);
	assign push = info.valid && info.ready;
	assign q_valid = (count_q != '0);
	assign q_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{info_bit: info.info_bit, frame_end: info.frame_end,
				tail_req: info.frame_end & settings.term};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			case ({push, q_pop})
				2'b10: count_q <= count_q + Q_CW'(1);
				2'b01: count_q <= count_q - Q_CW'(1);
				default: ;
			endcase
		end
	end
endmodule

### rtl/cenc_back.sv
// Back end: shift state, tail sequencer, parity generation and output register.
`timescale 1ns / 1ps
`include "convolutional_encoder_unit_macros.svh"
module cenc_back
	import cenc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input cfg_t settings,
	input logic q_valid,
	input q_item_t q_item,
	output logic q_pop,
	cenc_out_if.source code
);
	logic [ST_W-1:0] shift_q;
	logic [K_W-1:0] tail_cnt_q;
	logic out_valid_q;
	logic [CODE_W-1:0] code_q;
	logic is_tail_q;
	logic last_q;

	logic tail_active;
	logic adv;
	logic step_bit;
	logic step_last;
	logic frame_done;
	logic [MAX_K-1:0] kmask;
	logic [MAX_K-1:0] topbit;
	logic [ST_W-1:0] smask;
	logic [ST_W-1:0] st;
	logic [MAX_K-1:0] enc_a;
	logic [MAX_K-1:0] enc_b;
	logic fb_bit;
	logic [CODE_W-1:0] code_d;
	logic [ST_W-1:0] shift_d;

	assign tail_active = (tail_cnt_q != '0);
	assign adv = (tail_active || q_valid) && (!out_valid_q || code.ready);
	assign q_pop = adv && !tail_active;

	always_comb begin
		step_bit = tail_active ? 1'b0 : q_item.info_bit;
		if (tail_active) begin
			step_last = (tail_cnt_q == K_W'(1));
			frame_done = step_last;
		end else begin
			step_last = !q_item.tail_req;
			frame_done = q_item.frame_end && !q_item.tail_req;
		end
		for (int i = 0; i < MAX_K; i++) begin
			kmask[i] = (i < int'(settings.k));
			topbit[i] = (i == int'(settings.k_minus1));
		end
		for (int i = 0; i < ST_W; i++) begin
			smask[i] = (i < int'(settings.k_minus1));
		end
		st = shift_q & smask;
		enc_a = {1'b0, st} | (step_bit ? topbit : '0);
		fb_bit = ^(enc_a & settings.fb & kmask);
		if (settings.fb != '0) begin
			enc_b = {1'b0, st} | (fb_bit ? topbit : '0);
		end else begin
			enc_b = enc_a;
		end
		for (int p = 0; p < CODE_W; p++) begin
			code_d[p] = settings.gen_en[p] & (^(enc_b & settings.gen[p] & kmask));
		end
		shift_d = enc_b[MAX_K-1:1] & smask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			tail_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				shift_q <= frame_done ? '0 : shift_d;
				if (tail_active) begin
					tail_cnt_q <= tail_cnt_q - K_W'(1);
				end else if (q_item.tail_req) begin
					tail_cnt_q <= settings.k_minus1;
				end
				out_valid_q <= 1'b1;
			end else if (code.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_q <= code_d;
			is_tail_q <= tail_active;
			last_q <= step_last;
		end
	end

	assign code.valid = out_valid_q;
	assign code.code_bits = code_q;
	assign code.is_tail = is_tail_q;
	assign code.last_of_run = last_q;

	`CENC_ASSERT_IMP(a_no_pop_in_tail, clk, arst_n, tail_active, !q_pop,
		"Queue popped while tail steps are pending.")
	`CENC_ASSERT_NXT(a_state_clear_at_frame_end, clk, arst_n, adv && frame_done,
		shift_q == '0, "Shift state not cleared after frame end.")
	`CENC_ASSERT_NXT(a_tail_marks_result, clk, arst_n, adv && tail_active,
		out_valid_q && is_tail_q, "Tail step did not produce a tail result.")
	`CENC_ASSERT_IMP(a_unused_gens_zero, clk, arst_n, adv,
		(code_d & ~settings.gen_en) == '0, "Inactive generator produced a code bit.")
endmodule

### rtl/convolutional_encoder_unit.sv
// Top level of the rate 1/n convolutional encoder with feedback and frame tail.
// Usage:
// The info channel carries one information bit and a frame end flag per transaction.
// The code channel returns one transaction per encoder step, with one parity bit per
// active generator, a tail flag and a flag on the last result caused by an input.
// The cfg channel writes one register per transaction, by index, and is always ready;
// write it only while the encoder is idle.
// Each input is written into the queue and from there into the output register. Throughput
// is one input bit per cycle while the receiver does not stall; an input that ends a frame
// with termination enabled is followed by its K-1 tail steps, one per cycle, before the next.
// A four entry queue separates the input side from the encoder, so input keeps being
// taken while results stall. When the receiver stalls, the single output register holds
// and the back end waits; the queue fills and then deasserts ready on the info channel.
// Reset clears the shift state, the queue and the output register and loads the
// default configuration (K of 7, generators 121 and 91, no feedback, no tail).
`timescale 1ns / 1ps
module convolutional_encoder_unit
	import cenc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	cenc_in_if.sink info,
	cenc_out_if.source code,
	cenc_cfg_if.sink cfg
);
	cfg_t settings;
	logic q_valid;
	q_item_t q_item;
	logic q_pop;

	cenc_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.settings(settings)
	);

	cenc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.info(info),
		.settings(settings),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	cenc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.settings(settings),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.code(code)
	);
endmodule

### test/tb.sv
// Self-checking testbench for the convolutional encoder: scoreboard, stimulus and handshakes.
`timescale 1ns / 1ps
module tb;
	import cenc_pkg::*;

	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [CODE_W-1:0] code_bits;
		logic is_tail;
		logic last_of_run;
	} code_word_t;

	class code_scoreboard;
		logic [3:0] k_field;
		logic [2:0] gen_count;
		logic [MASK_W-1:0] gen_mask[MAX_GEN];
		logic [MASK_W-1:0] fb_mask;
		logic tail_on;
		logic [ST_W-1:0] history;
		code_word_t expected_codes[$];
		int failures;

		function new();
			k_field = 4'd7;
			gen_count = 3'd2;
			gen_mask[0] = 9'd121;
			gen_mask[1] = 9'd91;
			gen_mask[2] = '0;
			gen_mask[3] = '0;
			fb_mask = '0;
			tail_on = 1'b0;
			history = '0;
			failures = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_CONSTRAINT_LENGTH: k_field = v[3:0];
				REG_NUM_GENERATORS: gen_count = v[2:0];
				REG_GENERATOR_0: gen_mask[0] = v;
				REG_GENERATOR_1: gen_mask[1] = v;
				REG_GENERATOR_2: gen_mask[2] = v;
				REG_GENERATOR_3: gen_mask[3] = v;
				REG_FEEDBACK_MASK: fb_mask = v;
				REG_TERMINATE_ENABLE: tail_on = v[0];
				default: ;
			endcase
		endfunction

		function logic [CODE_W-1:0] encode_step(logic b, int k);
			logic [MAX_K-1:0] kmask;
			logic [MAX_K-1:0] window;
			logic [ST_W-1:0] smask;
			logic [ST_W-1:0] held;
			logic [CODE_W-1:0] codes;
			int n;
			kmask = MAX_K'((1 << k) - 1);
			smask = ST_W'((1 << (k - 1)) - 1);
			held = history & smask;
			window = {1'b0, held} | (MAX_K'(b) << (k - 1));
			// A recursive code replaces the incoming bit with the feedback parity.
			if (fb_mask != '0) begin
				window = {1'b0, held} | (MAX_K'(^(window & fb_mask & kmask)) << (k - 1));
			end
			n = (gen_count > MAX_GEN) ? MAX_GEN : int'(gen_count);
			codes = '0;
			for (int p = 0; p < n; p++) begin
				codes[p] = ^(window & gen_mask[p] & kmask);
			end
			history = ST_W'(window >> 1) & smask;
			return codes;
		endfunction

		function void note_input(logic b, logic e);
			int k;
			int steps;
			code_word_t w;
			k = (k_field < 2) ? 2 : ((k_field > MAX_K) ? MAX_K : int'(k_field));
			steps = (e && tail_on) ? k : 1;
			for (int i = 0; i < steps; i++) begin
				w.code_bits = encode_step((i == 0) ? b : 1'b0, k);
				w.is_tail = (i != 0);
				w.last_of_run = (i == steps - 1);
				expected_codes.push_back(w);
			end
			if (e) begin
				history = '0;
			end
		endfunction

		function void check(logic [CODE_W-1:0] code_bits, logic is_tail, logic last_of_run);
			code_word_t want;
			if (expected_codes.size() == 0) begin
				$error("unexpected code transaction: code_bits %0h is_tail %0b last_of_run %0b",
					code_bits, is_tail, last_of_run);
				failures++;
				return;
			end
			want = expected_codes.pop_front();
			if (code_bits !== want.code_bits) begin
				$error("code_bits: expected %0h, actual %0h", want.code_bits, code_bits);
				failures++;
			end
			if (is_tail !== want.is_tail) begin
				$error("is_tail: expected %0b, actual %0b", want.is_tail, is_tail);
				failures++;
			end
			if (last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0b, actual %0b", want.last_of_run, last_of_run);
				failures++;
			end
		endfunction

		function int pending();
			return expected_codes.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit steady = 1'b0;
	code_scoreboard board = new();

	cenc_in_if info_ch();
	cenc_out_if code_ch();
	cenc_cfg_if cfg_ch();

	convolutional_encoder_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.info(info_ch),
		.code(code_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				board.write_reg(reg_idx_t'(cfg_ch.index), cfg_ch.data);
			end
			if (info_ch.valid && info_ch.ready) begin
				board.note_input(info_ch.info_bit, info_ch.frame_end);
			end
			if (code_ch.valid && code_ch.ready) begin
				board.check(code_ch.code_bits, code_ch.is_tail, code_ch.last_of_run);
			end
		end
	end

	initial begin
		int stall;
		code_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				code_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			code_ch.ready <= 1'b1;
			do @(posedge clk); while (!code_ch.valid);
		end
	end

	task automatic set_reg(reg_idx_t idx, int v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= CFG_DATA_W'(v);
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic configure(int k, int n, int g0, int g1, int g2, int g3, int fb, int term);
		set_reg(REG_CONSTRAINT_LENGTH, k);
		set_reg(REG_NUM_GENERATORS, n);
		set_reg(REG_GENERATOR_0, g0);
		set_reg(REG_GENERATOR_1, g1);
		set_reg(REG_GENERATOR_2, g2);
		set_reg(REG_GENERATOR_3, g3);
		set_reg(REG_FEEDBACK_MASK, fb);
		set_reg(REG_TERMINATE_ENABLE, term);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_bit(logic b, logic e);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			info_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		info_ch.valid <= 1'b1;
		info_ch.info_bit <= b;
		info_ch.frame_end <= e;
		do @(posedge clk); while (!info_ch.ready);
	endtask

	task automatic drain();
		info_ch.valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	task automatic random_phase(int n_items);
		int k;
		int n;
		k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 9);
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
		configure(k, n, $urandom_range(0, 511), $urandom_range(0, 511),
			$urandom_range(0, 511), $urandom_range(0, 511),
			$urandom_range(0, 1) ? 0 : $urandom_range(1, 511),
			($urandom_range(0, 2) != 0) ? 1 : 0);
		steady = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n_items; i++) begin
			send_bit($urandom_range(0, 1), $urandom_range(0, 7) == 0);
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		info_ch.valid <= 1'b0;
		info_ch.info_bit <= 1'b0;
		info_ch.frame_end <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_CONSTRAINT_LENGTH;
		cfg_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Default code straight out of reset; the frame is left open at the end.
		send_bit(1'b1, 1'b0);
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b0);
		send_bit(1'b1, 1'b1);
		send_bit(1'b0, 1'b0);
		drain();

		// Longest register, all four generators, full tails.
		configure(9, 4, 511, 341, 170, 256, 0, 1);
		send_bit(1'b1, 1'b0);
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b1);
		send_bit(1'b1, 1'b1);
		drain();

		// Shortest register with feedback, so the tail does not flush to zero.
		configure(2, 1, 3, 0, 0, 0, 3, 1);
		send_bit(1'b1, 1'b0);
		send_bit(1'b0, 1'b1);
		send_bit(1'b1, 1'b0);
		drain();

		// Oversized length and generator count, changed in the middle of a frame.
		configure(15, 7, 511, 0, 511, 0, 0, 0);
		send_bit(1'b1, 1'b0);
		send_bit(1'b1, 1'b0);
		send_bit(1'b0, 1'b1);
		drain();

		// Length below the minimum with no generators active.
		configure(0, 0, 511, 511, 511, 511, 511, 1);
		send_bit(1'b1, 1'b1);
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b1);
		drain();

		// Feedback mask set only above the register, which forces a zero input.
		configure(3, 2, 511, 7, 0, 0, 504, 1);
		send_bit(1'b1, 1'b0);
		send_bit(1'b1, 1'b0);
		send_bit(1'b1, 1'b1);
		drain();

		for (int phase = 0; phase < 7; phase++) begin
			random_phase(15);
		end

		repeat (6) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

### sim.f
+incdir+rtl
rtl/cenc_pkg.sv
rtl/cenc_if.sv
rtl/cenc_regs.sv
rtl/cenc_front.sv
rtl/cenc_back.sv
rtl/convolutional_encoder_unit.sv
test/tb.sv
